### src/pcm16_pkg.sv
// ----------------------------------------------------------------------------
// pcm16_pkg
// Shared constants and types for the int16 sample converter.
// ----------------------------------------------------------------------------
`default_nettype none
package pcm16_pkg;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOAT_MODE   = 1'd1;
    localparam logic [5:0] WIDTH_8  = 6'd8;
    localparam logic [5:0] WIDTH_16 = 6'd16;
    localparam logic [5:0] WIDTH_24 = 6'd24;
    localparam logic [5:0] WIDTH_32 = 6'd32;
    localparam logic [5:0] WIDTH_RESET = 6'd16;

    typedef struct packed {
        logic [5:0] sample_width;
        logic       float_mode;
    } t_cfg;
endpackage
`default_nettype wire

### src/pcm_sample_to_int16_unit.sv
// Registered path: input register, then result register.
// Throughput: one sample per cycle while the output is not stalled; the
// conversion is a single combinational pass between the two register stages.
// Reset: synchronous active low; clears valid flags, width 16, integer mode.
`default_nettype none
module pcm_sample_to_int16_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [31:0]            i_raw_word,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic signed [15:0]          o_pcm_value,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [pcm16_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);
    pcm16_pkg::t_cfg    r_cfg;
    logic               r_in_valid;
    logic [31:0]        r_in_word;
    logic               r_out_valid;
    logic signed [15:0] r_out_value;
    logic signed [15:0] conv_value;
    logic               adv;

    assign adv         = !r_out_valid || !i_stall;
    assign o_stall     = !adv;
    assign o_valid     = r_out_valid;
    assign o_pcm_value = r_out_value;
    assign o_cfg_ready = 1'b1;

    pcm16_conv u_conv (.i_word(r_in_word), .i_cfg(r_cfg), .o_value(conv_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_width <= pcm16_pkg::WIDTH_RESET;
            r_cfg.float_mode   <= 1'b0;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pcm16_pkg::REG_SAMPLE_WIDTH: r_cfg.sample_width <= i_cfg_data[5:0];
                    pcm16_pkg::REG_FLOAT_MODE:   r_cfg.float_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (adv) begin
                r_in_valid  <= i_valid;
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_word   <= i_raw_word;
            r_out_value <= conv_value;
        end
    end

    // held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pcm_value)))
        else $error("result changed under stall");
    // input stage moves into output stage when not stalled
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_stall) |=> o_valid)
        else $error("item lost between stages");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("spurious stall");
endmodule
`default_nettype wire

### src/pcm16_conv.sv
// ----------------------------------------------------------------------------
// pcm16_conv
// Combinational conversion of one sample word to a signed 16-bit value.
// ----------------------------------------------------------------------------
`default_nettype none
module pcm16_conv (
    input  wire logic [31:0]     i_word,
    input  wire pcm16_pkg::t_cfg i_cfg,
    output logic signed [15:0]   o_value
);
    logic        neg;
    logic [7:0]  ex;
    logic [23:0] m;
    logic [7:0]  sh;
    logic [4:0]  shs;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] half;
    logic [24:0] qr;
    logic [16:0] limit;
    logic [16:0] mag;
    logic [15:0] fval;
    logic [15:0] ival;

    always_comb begin
        neg   = i_word[31];
        ex    = i_word[30:23];
        m     = {1'b1, i_word[22:0]};
        limit = neg ? 17'd32768 : 17'd32767;
        sh    = 8'd135 - ex;
        shs   = sh[4:0];
        q     = m >> shs;
        rem   = m & ((24'd1 << shs) - 24'd1);
        half  = (shs == 5'd0) ? 24'd0 : (24'd1 << (shs - 5'd1));
        qr    = {1'b0, q};
        if (shs != 5'd0 && (rem > half || (rem == half && q[0])))
            qr = qr + 25'd1;
        if (ex == 8'hFF) begin
            mag = (i_word[22:0] != 23'd0) ? 17'd0 : limit;
        end else if (ex == 8'd0) begin
            mag = 17'd0;
        end else if (ex >= 8'd135) begin
            mag = limit;
        end else if (sh >= 8'd25) begin
            mag = 17'd0;
        end else if (qr > {8'd0, limit}) begin
            mag = limit;
        end else begin
            mag = qr[16:0];
        end
        fval = neg ? 16'(17'd0 - mag) : mag[15:0];

        unique case (i_cfg.sample_width)
            pcm16_pkg::WIDTH_8:  ival = {i_word[7:0] ^ 8'h80, 8'h00};
            pcm16_pkg::WIDTH_16: ival = i_word[15:0];
            pcm16_pkg::WIDTH_24: ival = i_word[23:8];
            pcm16_pkg::WIDTH_32: ival = i_word[31:16];
            default:             ival = 16'd0;
        endcase
        o_value = i_cfg.float_mode ? fval : ival;
    end
endmodule
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: pcm_sample_to_int16_unit testbench
// Drives sample words through the converter under several width and float
// settings, with random idle cycles on both sides, and checks every result
// against an in-bench conversion model.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    localparam int N_RANDOM = 500;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_raw_word;
    logic        o_valid;
    logic        i_stall;
    logic signed [15:0] o_pcm_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [pcm16_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    pcm_sample_to_int16_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_raw_word(i_raw_word),
        .o_valid(o_valid), .i_stall(i_stall), .o_pcm_value(o_pcm_value),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    pcm16_pkg::t_cfg cur_cfg;
    logic [15:0] pending_pcm[$];
    int  n_errors;
    bit  sink_no_idle;
    bit  src_no_idle;

    typedef struct {
        logic [31:0] word;
        bit          has_exp;
        logic [15:0] exp_pcm;
    } t_vec;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("FAIL pcm_sample_to_int16_unit");
        $finish;
    end

    function automatic logic [15:0] float_to_int16(input logic [31:0] w);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [23:0] m;
        logic [16:0] lim;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] mag;
        int          sh;
        neg = w[31];
        ex  = w[30:23];
        fr  = w[22:0];
        lim = neg ? 17'd32768 : 17'd32767;
        if (ex == 8'hFF) begin
            if (fr != 0) return 16'h0000;
            mag = lim;
        end else if (ex == 8'h00) begin
            mag = 0;
        end else if (ex >= 8'd135) begin
            mag = lim;
        end else begin
            m  = {1'b1, fr};
            sh = 135 - ex;
            if (sh >= 25) begin
                mag = 0;
            end else begin
                q    = 32'(m) >> sh;
                rem  = 32'(m) & ((32'd1 << sh) - 1);
                half = 32'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 1;
                mag = q;
            end
            if (mag > lim) mag = lim;
        end
        if (neg) return 16'(32'd0 - mag);
        return mag[15:0];
    endfunction

    function automatic logic [15:0] convert_sample(input pcm16_pkg::t_cfg c,
                                                   input logic [31:0] w);
        if (c.float_mode) return float_to_int16(w);
        case (c.sample_width)
            pcm16_pkg::WIDTH_8:  return {w[7] ^ 1'b1, w[6:0], 8'h00};
            pcm16_pkg::WIDTH_16: return w[15:0];
            pcm16_pkg::WIDTH_24: return w[23:8];
            pcm16_pkg::WIDTH_32: return w[31:16];
            default:             return 16'h0000;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // result sink with random stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pcm.size() == 0) begin
                report_mismatch("unexpected result", o_pcm_value, 16'h0);
            end else begin
                logic [15:0] want;
                want = pending_pcm.pop_front();
                if (o_pcm_value !== want) report_mismatch("pcm_value", o_pcm_value, want);
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (!sink_no_idle && $urandom_range(0, 99) < 10);
    end

    // valid stays high between back-to-back transactions
    task automatic send_word(input logic [31:0] w, input bit has_exp, input logic [15:0] e);
        while (!src_no_idle && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_raw_word <= w;
        if (has_exp && e !== convert_sample(cur_cfg, w))
            report_mismatch("table row", convert_sample(cur_cfg, w), e);
        pending_pcm.push_back(convert_sample(cur_cfg, w));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_pcm.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [pcm16_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (idx == pcm16_pkg::REG_SAMPLE_WIDTH) cur_cfg.sample_width = d[5:0];
        else cur_cfg.float_mode = d[0];
    endtask

    task automatic set_mode(input logic [5:0] wdt, input bit fm);
        drain_results();
        write_reg(pcm16_pkg::REG_SAMPLE_WIDTH, {$urandom} & 32'hFFFF_FFC0 | 32'(wdt));
        write_reg(pcm16_pkg::REG_FLOAT_MODE, {$urandom} & 32'hFFFF_FFFE | 32'(fm));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_table(input t_vec v[]);
        foreach (v[k]) send_word(v[k].word, v[k].has_exp, v[k].exp_pcm);
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w[30:23] = 8'hFF;
            1: w[30:23] = 8'h00;
            2, 3: w[30:23] = 8'(110 + $urandom_range(0, 25));
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        t_vec tbl_int[];
        t_vec tbl_flt[];
        logic [5:0] widths[6];
        int k;
        widths = '{pcm16_pkg::WIDTH_8, pcm16_pkg::WIDTH_16, pcm16_pkg::WIDTH_24,
                   pcm16_pkg::WIDTH_32, 6'd0, 6'd63};
        n_errors = 0;
        sink_no_idle = 0;
        src_no_idle = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_raw_word = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cur_cfg.sample_width = pcm16_pkg::WIDTH_RESET;
        cur_cfg.float_mode = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset: 16-bit integer passthrough
        tbl_int = '{
            '{32'h1234_5678, 1, 16'h5678},
            '{32'hFFFF_8000, 1, 16'h8000},
            '{32'h0000_7FFF, 1, 16'h7FFF},
            '{32'hFFFF_FFFF, 1, 16'hFFFF}
        };
        run_table(tbl_int);

        set_mode(pcm16_pkg::WIDTH_8, 0);
        tbl_int = '{'{32'h0000_0000, 1, 16'h8000}, '{32'hFFFF_FFFF, 1, 16'h7F00},
                    '{32'h0000_0080, 1, 16'h0000}};
        run_table(tbl_int);
        set_mode(pcm16_pkg::WIDTH_24, 0);
        tbl_int = '{'{32'h00AB_CDEF, 1, 16'hABCD}, '{32'hFFFF_FFFF, 1, 16'hFFFF}};
        run_table(tbl_int);
        set_mode(pcm16_pkg::WIDTH_32, 0);
        tbl_int = '{'{32'h8000_1234, 1, 16'h8000}};
        run_table(tbl_int);
        // unsupported width gives zero
        set_mode(6'd63, 0);
        tbl_int = '{'{32'hFFFF_FFFF, 1, 16'h0000}};
        run_table(tbl_int);

        // float mode, width ignored
        set_mode(6'd5, 1);
        tbl_flt = '{
            '{32'h7F80_0000, 1, 16'h7FFF},   // +inf
            '{32'hFF80_0000, 1, 16'h8000},   // -inf
            '{32'h7FC0_0000, 1, 16'h0000},   // nan
            '{32'hFF80_0001, 1, 16'h0000},   // nan
            '{32'h8000_0000, 1, 16'h0000},   // negative zero
            '{32'h0000_0001, 1, 16'h0000},   // subnormal
            '{32'h3F80_0000, 1, 16'h7FFF},   // 1.0 clamps
            '{32'hBF80_0000, 1, 16'h8000},   // -1.0
            '{32'h3F00_0000, 1, 16'h4000},   // 0.5
            '{32'h3F7F_FFFF, 0, 16'h0000},   // just below one
            '{32'h3800_0000, 0, 16'h0000},   // one lsb, exact
            '{32'h38C0_0000, 0, 16'h0000},   // three lsb, exact
            '{32'h4F00_0000, 1, 16'h7FFF}    // huge
        };
        run_table(tbl_flt);

        // random phases across settings
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 50 == 0) begin
                if ($urandom_range(0, 2) == 0) set_mode(6'($urandom), 1);
                else set_mode(($urandom_range(0, 3) == 0) ? 6'($urandom)
                              : widths[$urandom_range(0, 5)], 0);
                sink_no_idle = (k == 150);
                src_no_idle = (k == 150);
            end
            if (k == 300) drain_results();   // sender waits out the pipeline
            send_word(cur_cfg.float_mode ? random_float() : $urandom, 0, 16'h0);
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("PASS pcm_sample_to_int16_unit");
        end else begin
            $display("FAIL pcm_sample_to_int16_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
src/pcm16_pkg.sv
src/pcm16_conv.sv
src/pcm_sample_to_int16_unit.sv
verif/tb.sv
